// ----- rtl/palmdoc_lz77_decompressor_top_defines.svh -----
// Assertion macros for the PalmDoc LZ77 decompressor.
`ifndef PALMDOC_LZ77_DECOMPRESSOR_TOP_DEFINES_SVH
`define PALMDOC_LZ77_DECOMPRESSOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("palmdoc: assertion failed");
`define PD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("palmdoc: assertion failed");
`else
`define PD_ASSERT(lbl, prop)
`define PD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/palmdoc_pkg.sv -----
`timescale 1ns / 1ps
package palmdoc_pkg;

  localparam int unsigned HistDepth = 2048;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned CountW    = HistAw + 1;
  localparam int unsigned LenW      = 4;
  localparam int unsigned LenBase   = 3;

  localparam logic [7:0] SpaceByte = 8'h20;
  localparam logic [7:0] PassMax   = 8'h08;
  localparam logic [7:0] LitMax    = 8'h7F;
  localparam logic [7:0] PairMin   = 8'hC0;
  localparam logic [7:0] FlipMask  = 8'h80;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LITERAL,
    MODE_AWAIT_LOW,
    MODE_STOPPED
  } mode_e;

  typedef enum logic [1:0] {
    ST_IN,
    ST_PAIR,
    ST_COPY
  } state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       record_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    out_word_t         word;
  } emit_t;

  typedef struct packed {
    logic              we;
    logic [HistAw-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [HistAw-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic busy;
  } dec_status_t;

endpackage

// ----- rtl/palmdoc_hist_ram.sv -----
`timescale 1ns / 1ps
module palmdoc_hist_ram (
  input  logic                  clk_i,
  input  palmdoc_pkg::ram_req_t req_i,
  output logic [7:0]            rdata_o
);
  import palmdoc_pkg::*;

  logic [7:0] mem_q [HistDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/palmdoc_dec.sv -----
`timescale 1ns / 1ps
module palmdoc_dec (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  palmdoc_pkg::in_word_t    in_word_i,
  output logic                     in_stall_o,
  input  logic                     emit_ok_i,
  output palmdoc_pkg::emit_t       emit_o,
  output palmdoc_pkg::ram_req_t    ram_req_o,
  input  logic [7:0]               ram_rdata_i,
  output palmdoc_pkg::dec_status_t status_o
);
  import palmdoc_pkg::*;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [HistAw-1:0]   wp_q, wp_d;
  logic [CountW-1:0]   be_q, be_d;
  logic [LenW-1:0]     lit_q, lit_d;
  logic [7:0]          pend_q, pend_d;
  logic [HistAw-1:0]   dist_q, dist_d;
  logic [LenW-1:0]     rem_q, rem_d;
  logic                rec_q, rec_d;
  logic                fwd_q, fwd_d;
  logic [7:0]          prev_q, prev_d;
  logic [7:0]          pair_q, pair_d;

  logic                accept;
  logic [7:0]          c;
  logic [15:0]         tok;
  logic [HistAw-1:0]   dist_in;
  logic [LenW-1:0]     len_in;
  logic [CountW-1:0]   be_inc;
  logic [7:0]          copy_data;
  logic                copy_last;
  logic                ref_start;
  logic                pair_start;
  logic                clear;

  assign in_stall_o = (state_q != ST_IN) || !emit_ok_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign c          = in_word_i.in_byte;
  assign tok        = {pend_q, c};
  assign dist_in    = tok[HistAw+2:3];
  assign len_in     = {1'b0, tok[2:0]} + LenW'(LenBase);
  assign be_inc     = (be_q == CountW'(HistDepth)) ? be_q : be_q + 1'b1;
  assign copy_data  = fwd_q ? prev_q : ram_rdata_i;
  assign copy_last  = (rem_q == LenW'(1)) || ({1'b0, dist_q} > be_inc);
  assign ref_start  = accept && (mode_q == MODE_AWAIT_LOW) && (dist_in != '0) &&
                      ({1'b0, dist_in} <= be_q);
  assign pair_start = accept && (mode_q == MODE_IDLE) && (c >= PairMin);
  assign status_o.busy = (state_q != ST_IN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IN: begin
        if (ref_start) begin
          state_d = ST_COPY;
        end else if (pair_start) begin
          state_d = ST_PAIR;
        end
      end
      ST_PAIR: begin
        if (emit_ok_i) begin
          state_d = ST_IN;
        end
      end
      ST_COPY: begin
        if (emit_ok_i && copy_last) begin
          state_d = ST_IN;
        end
      end
      default: state_d = ST_IN;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    wp_d      = wp_q;
    be_d      = be_q;
    lit_d     = lit_q;
    pend_d    = pend_q;
    dist_d    = dist_q;
    rem_d     = rem_q;
    rec_d     = rec_q;
    fwd_d     = fwd_q;
    prev_d    = prev_q;
    pair_d    = pair_q;
    emit_o    = '0;
    ram_req_o = '0;
    clear     = 1'b0;

    case (state_q)
      ST_IN: begin
        if (accept) begin
          case (mode_q)
            MODE_LITERAL: begin
              emit_o.valid            = 1'b1;
              emit_o.word.out_byte    = c;
              emit_o.word.last_of_run = 1'b1;
              lit_d = lit_q - 1'b1;
              if (lit_q == LenW'(1)) begin
                mode_d = MODE_IDLE;
              end
            end
            MODE_AWAIT_LOW: begin
              mode_d = MODE_IDLE;
              if (dist_in == '0) begin
                mode_d = MODE_STOPPED;
              end else if (ref_start) begin
                dist_d          = dist_in;
                rem_d           = len_in;
                fwd_d           = 1'b0;
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = wp_q - dist_in;
              end
            end
            MODE_STOPPED: begin
            end
            default: begin
              if (c <= LitMax && (c == '0 || c > PassMax)) begin
                emit_o.valid            = 1'b1;
                emit_o.word.out_byte    = c;
                emit_o.word.last_of_run = 1'b1;
              end else if (c <= PassMax) begin
                lit_d  = c[LenW-1:0];
                mode_d = MODE_LITERAL;
              end else if (c >= PairMin) begin
                emit_o.valid            = 1'b1;
                emit_o.word.out_byte    = SpaceByte;
                emit_o.word.last_of_run = 1'b0;
                pair_d = c ^ FlipMask;
              end else begin
                pend_d = c;
                mode_d = MODE_AWAIT_LOW;
              end
            end
          endcase
          if (ref_start || pair_start) begin
            rec_d = in_word_i.record_end;
          end else if (in_word_i.record_end) begin
            clear = 1'b1;
          end
        end
      end
      ST_PAIR: begin
        if (emit_ok_i) begin
          emit_o.valid            = 1'b1;
          emit_o.word.out_byte    = pair_q;
          emit_o.word.last_of_run = 1'b1;
          clear = rec_q;
        end
      end
      ST_COPY: begin
        if (emit_ok_i) begin
          emit_o.valid            = 1'b1;
          emit_o.word.out_byte    = copy_data;
          emit_o.word.last_of_run = copy_last;
          rem_d  = rem_q - 1'b1;
          prev_d = copy_data;
          // distance one reads the slot written this cycle: take it from prev
          fwd_d  = (dist_q == HistAw'(1));
          if (copy_last) begin
            clear = rec_q;
          end else begin
            ram_req_o.re    = (dist_q != HistAw'(1));
            ram_req_o.raddr = wp_q + HistAw'(1) - dist_q;
          end
        end
      end
      default: begin
      end
    endcase

    if (emit_o.valid) begin
      ram_req_o.we    = 1'b1;
      ram_req_o.waddr = wp_q;
      ram_req_o.wdata = emit_o.word.out_byte;
      wp_d = wp_q + 1'b1;
      be_d = be_inc;
    end

    if (clear) begin
      wp_d   = '0;
      be_d   = '0;
      mode_d = MODE_IDLE;
      lit_d  = '0;
      pend_d = '0;
      rec_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IN;
      mode_q  <= MODE_IDLE;
      wp_q    <= '0;
      be_q    <= '0;
      lit_q   <= '0;
      pend_q  <= '0;
      rem_q   <= '0;
      rec_q   <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      wp_q    <= wp_d;
      be_q    <= be_d;
      lit_q   <= lit_d;
      pend_q  <= pend_d;
      rem_q   <= rem_d;
      rec_q   <= rec_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    prev_q <= prev_d;
    pair_q <= pair_d;
  end

endmodule

// ----- rtl/palmdoc_lz77_decompressor_top.sv -----
// Output: a literal word is registered at the output in the cycle after acceptance; a
// back-reference's second byte starts a history read, its first byte then passes the
// RAM read and output registers, then the rest 1 byte per cycle while not stalled.
// A space pair or back-reference holds the input until its last byte is emitted.
// Reset: control state clears at once; history is not cleared and needs no sweep.
`timescale 1ns / 1ps
`include "palmdoc_lz77_decompressor_top_defines.svh"
module palmdoc_lz77_decompressor_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  palmdoc_pkg::in_word_t  in_word_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output palmdoc_pkg::out_word_t out_word_o,
  input  logic                   out_stall_i
);
  import palmdoc_pkg::*;

  emit_t       emit;
  ram_req_t    ram_req;
  logic [7:0]  ram_rdata;
  dec_status_t status;
  logic        emit_ok;
  logic        out_valid_q;
  out_word_t   out_word_q;

  assign emit_ok = !out_valid_q || !out_stall_i;

  palmdoc_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .emit_ok_i   (emit_ok),
    .emit_o      (emit),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .status_o    (status)
  );

  palmdoc_hist_ram u_hist (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_word_q <= emit.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `PD_ASSERT(a_emit_has_room, emit.valid |-> (!out_valid_q || !out_stall_i))
  `PD_ASSERT(a_no_rw_collision, (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
  `PD_ASSERT(a_last_frees_dec, (emit.valid && emit.word.last_of_run) |=> !status.busy)
  `PD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (!out_valid_o || !rst_ni))

endmodule

// ----- tb/sv/palmdoc_lz77_decompressor_top_test.sv -----
`timescale 1ns / 1ps
module palmdoc_lz77_decompressor_top_test;
  import palmdoc_pkg::*;

  localparam int unsigned DrainPad    = 16;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomWords = 260;
  localparam int unsigned MaxDist     = HistDepth - 1;
  localparam int unsigned ReportMax   = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;
  logic      out_stall = 1'b0;

  always #4 clk = ~clk;

  palmdoc_lz77_decompressor_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_word_i   (in_word),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_word_o  (out_word),
    .out_stall_i (out_stall)
  );

  // decoder image
  logic [7:0]        hist_q [HistDepth];
  logic [HistAw-1:0] wr_ptr;
  logic [CountW-1:0] emitted_cnt;
  mode_e             dec_mode;
  logic [3:0]        pass_left;
  logic [7:0]        ref_hi;

  out_word_t  run_q[$];
  out_word_t  expected_q[$];
  logic [7:0] record_q[$];

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned steady_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned idle_cycles = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < ReportMax) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic void reset_decoder();
    wr_ptr      = '0;
    emitted_cnt = '0;
    dec_mode    = MODE_IDLE;
    pass_left   = '0;
    ref_hi      = '0;
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    hist_q[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    if (emitted_cnt < HistDepth) emitted_cnt = emitted_cnt + 1'b1;
    run_q.push_back('{out_byte: b, last_of_run: 1'b0});
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic rec_end);
    logic [15:0]       pair;
    logic [HistAw-1:0] ref_dist;
    int unsigned       count;
    run_q.delete();
    case (dec_mode)
      MODE_LITERAL: begin
        store_byte(b);
        pass_left = pass_left - 1'b1;
        if (pass_left == 0) dec_mode = MODE_IDLE;
      end
      MODE_AWAIT_LOW: begin
        pair     = {ref_hi, b};
        ref_dist = pair[13:3];
        count    = pair[2:0] + LenBase;
        dec_mode = MODE_IDLE;
        if (ref_dist == 0) begin
          dec_mode = MODE_STOPPED;
        end else begin
          for (int k = 0; k < count && ref_dist <= emitted_cnt; k++)
            store_byte(hist_q[wr_ptr - ref_dist]);
        end
      end
      MODE_STOPPED: begin
      end
      default: begin
        if (b != 8'h00 && b <= PassMax) begin
          pass_left = b[3:0];
          dec_mode  = MODE_LITERAL;
        end else if (b <= LitMax) begin
          store_byte(b);
        end else if (b >= PairMin) begin
          store_byte(SpaceByte);
          store_byte(b ^ FlipMask);
        end else begin
          ref_hi   = b;
          dec_mode = MODE_AWAIT_LOW;
        end
      end
    endcase
    if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
    foreach (run_q[i]) expected_q.push_back(run_q[i]);
    if (rec_end) reset_decoder();
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) steady_left = $urandom_range(10, 60);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic rec_end);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{in_byte: b, record_end: rec_end};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, rec_end);
    words_sent++;
  endtask

  task automatic send_record();
    foreach (record_q[i]) send_word(record_q[i], i == record_q.size() - 1);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);
  endtask

  // Token stream of at least target output bytes, maybe bad distances, optional broken tail.
  task automatic build_record(input int unsigned target, input bit broken, input bit long_refs);
    int unsigned out_len, ref_dist, n, pick, len_code;
    record_q.delete();
    out_len = 0;
    while (out_len < target) begin
      pick = long_refs ? $urandom_range(30, 99) : $urandom_range(0, 99);
      if (pick < 25) begin
        if ($urandom_range(0, 9) == 0) record_q.push_back(8'h00);
        else record_q.push_back(8'($urandom_range(PassMax + 1, LitMax)));
        out_len++;
      end else if (pick < 40) begin
        n = $urandom_range(1, PassMax);
        record_q.push_back(8'(n));
        repeat (n) record_q.push_back(8'($urandom_range(0, 255)));
        out_len += n;
      end else if (pick < 55) begin
        record_q.push_back(8'($urandom_range(PairMin, 255)));
        out_len += 2;
      end else begin
        if (out_len == 0 || (!long_refs && $urandom_range(0, 19) == 0))
          ref_dist = $urandom_range(0, MaxDist);
        else
          ref_dist = $urandom_range(1, (out_len > MaxDist) ? MaxDist : out_len);
        len_code = long_refs ? 7 : $urandom_range(0, 7);
        record_q.push_back(FlipMask | 8'(ref_dist >> 5));
        record_q.push_back(8'({ref_dist[4:0], len_code[2:0]}));
        if (ref_dist != 0 && ref_dist <= out_len) out_len += len_code + LenBase;
      end
    end
    if (broken) begin
      if ($urandom_range(0, 1) == 0) begin
        record_q.push_back(8'($urandom_range(FlipMask, PairMin - 1)));
      end else begin
        n = $urandom_range(1, PassMax);
        record_q.push_back(8'(n));
        repeat ($urandom_range(0, n - 1)) record_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_tokens();
    record_q = '{8'h00, 8'h09, 8'h7F, 8'hC0, 8'hFF, 8'h08,
                 8'h00, 8'h01, 8'h08, 8'h09, 8'h7F, 8'h80, 8'hBF, 8'hFF,
                 8'h01, 8'hC1};
    send_record();
  endtask

  task automatic test_back_references();
    // overlap copy, shortest copy, then a source far before the record start
    record_q = '{8'h41, 8'h42, 8'h80, 8'h0F, 8'h80, 8'h10, 8'hBF, 8'hF8};
    send_record();
  endtask

  task automatic test_record_ends();
    // zero distance stops the record
    record_q = '{8'h41, 8'h80, 8'h07, 8'h41, 8'hC5};
    send_record();
    // back-reference cut by record end
    record_q = '{8'h41, 8'h85};
    send_record();
    // pass-through cut by record end, then a clean record
    record_q = '{8'h05, 8'h61, 8'h62};
    send_record();
    record_q = '{8'h61};
    send_record();
  endtask

  task automatic test_long_record();
    // history wraps and the emitted count saturates; then the farthest distance
    build_record(HistDepth + 64, 1'b0, 1'b1);
    record_q.push_back(8'hBF);
    record_q.push_back(8'hFF);
    send_record();
  endtask

  task automatic test_random_records();
    int unsigned first, pick;
    first = words_sent;
    while (words_sent - first < RandomWords) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        record_q.delete();
        repeat ($urandom_range(1, 12)) record_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_record(($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 120),
                     pick >= 85, 1'b0);
      end
      send_record();
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:7]:   calm_left = $urandom_range(20, 80);
          [8:32]:  stall_left = $urandom_range(1, 3);
          [33:35]: stall_left = $urandom_range(10, 30);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h last %0b",
                                  out_word.out_byte, out_word.last_of_run));
      end else begin
        want = expected_q.pop_front();
        if (out_word.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    out_word.out_byte, want.out_byte));
        if (out_word.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                    out_word.last_of_run, want.last_of_run, want.out_byte));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("timeout: no word moved for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    reset_decoder();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_tokens();
    drain_results();
    test_back_references();
    drain_results();
    test_record_ends();
    drain_results();
    test_long_record();
    drain_results();
    test_random_records();
    drain_results();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
